/* rtl/dsss_matched_filter_peak_top_defines.svh */
// ----------------------------------------------------------------------------
// DSSS matched filter peak - assertion macros
// Shared concurrent assertion helpers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef DSSS_MATCHED_FILTER_PEAK_TOP_DEFINES_SVH
`define DSSS_MATCHED_FILTER_PEAK_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold on every clock edge outside reset
`define DMF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define DMF_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define DMF_ASSERT(lbl, clk, rst, prop, msg)
`define DMF_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

/* rtl/dsssmf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsssmf_pkg
// Widths, register codes and shared types of the DSSS matched filter peak.
// ----------------------------------------------------------------------------
package dsssmf_pkg;

   // sample and tap format
   localparam int SAMPLE_W   = 16;
   localparam int FRAC_SHIFT = SAMPLE_W - 1;

   // filter depth
   localparam int TAP_DEPTH = 256;
   localparam int TAP_IDX_W = $clog2(TAP_DEPTH);
   localparam int TAP_CNT_W = TAP_IDX_W + 1;

   // window
   localparam int WIN_MAX = 4096;
   localparam int POS_W   = $clog2(WIN_MAX);
   localparam int WIN_W   = POS_W + 1;

   // datapath widths
   localparam int MUL_W     = 2 * SAMPLE_W;
   localparam int ACC_W     = MUL_W + 1 + TAP_IDX_W;
   localparam int Y_W       = ACC_W - FRAC_SHIFT;
   localparam int MAG_W     = 2 * Y_W;
   localparam int SCALE_W   = 16;
   localparam int SCL_W     = Y_W + SCALE_W + 1;
   localparam int SCL_SHIFT = 16;
   localparam int SH_W      = SCL_W - SCL_SHIFT;
   localparam int OUT_W     = 16;

   // register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_ADDR_W = CSR_IDX_W + 2;
   localparam int CSR_DATA_W = 32;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_TAP_COUNT     = 2'd0;
   localparam csr_idx_type CSR_WINDOW_LENGTH = 2'd1;
   localparam csr_idx_type CSR_OUTPUT_SCALE  = 2'd2;

   localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 9'd1;
   localparam logic [WIN_W-1:0]     WIN_LEN_RST   = 13'd64;
   localparam logic [SCALE_W-1:0]   SCALE_RST     = 16'd2048;

   // request function codes
   localparam logic FUNC_TAP    = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
   } cplx_type;

   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctrl_type;

   typedef struct packed {
      logic clear;
      logic take;
   } mac_ctrl_type;

   typedef struct packed {
      logic sqr;
      logic cmp;
      logic scale;
   } peak_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_ACC,
      ST_SQR,
      ST_CMP,
      ST_SCALE,
      ST_EMIT
   } state_type;

endpackage

/* rtl/dsss_matched_filter_peak_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsss_matched_filter_peak_top
// Complex matched filter with windowed peak pick for DSSS despreading.
//
// The req channel carries taps (func 0, written at tap_index) and I/Q samples
// (func 1). Each sample enters a row of 256 cells holding the delay line and
// the taps; the row then rotates once through a single complex MAC at its head,
// one tap per cycle, so the 256-step rotation sets the sample rate. Taps and
// samples are taken only while idle: after its rotation a sample passes the
// accumulate, square and compare steps, at a window end also the scale and
// emit steps that load the scaled peak onto rsp. The rsp channel is an
// output register: new requests are taken while a result waits, and only a
// further window end stalls when the receiver holds off.
// Reset loads tap_count 1, window_length 64, output_scale 2048, clears the
// delay line and the window state; taps must be written before use.
// The csr port is APB-style, always ready, registers at byte 0, 4 and 8.
// ----------------------------------------------------------------------------
`include "dsss_matched_filter_peak_top_defines.svh"

module dsss_matched_filter_peak_top
   import dsssmf_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic [TAP_IDX_W-1:0]         req_tap_index,
   input  logic signed [SAMPLE_W-1:0]   req_value_re,
   input  logic signed [SAMPLE_W-1:0]   req_value_im,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [OUT_W-1:0]      rsp_peak_re,
   output logic signed [OUT_W-1:0]      rsp_peak_im,
   // register port
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   state_type                state_ff, state_in;
   logic [TAP_IDX_W-1:0]     cnt_ff, cnt_in;
   logic                     accept, smp_acc, tap_acc, load_rsp;
   logic [TAP_CNT_W-1:0]     tap_count_ff, tap_count_in;
   logic [WIN_W-1:0]         win_len_ff, win_len_in;
   logic [SCALE_W-1:0]       scale_ff, scale_in;
   logic                     csr_wr;
   csr_idx_type              csr_idx;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]  rsp_peak_re_ff, rsp_peak_re_in;
   logic signed [OUT_W-1:0]  rsp_peak_im_ff, rsp_peak_im_in;
   cplx_type                 req_value;
   cplx_type                 smp_chain [TAP_DEPTH];
   cplx_type                 tap_chain [TAP_DEPTH];
   logic [TAP_DEPTH-1:0]     tap_we;
   cell_ctrl_type            cell_ctrl;
   mac_ctrl_type             mac_ctrl;
   peak_ctrl_type            peak_ctrl;
   logic signed [ACC_W-1:0]  acc_re, acc_im;
   logic                     win_end;
   logic signed [OUT_W-1:0]  peak_re, peak_im;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      tap_count_in = tap_count_ff;
      win_len_in   = win_len_ff;
      scale_in     = scale_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_TAP_COUNT:     tap_count_in = csr_pwdata[TAP_CNT_W-1:0];
            CSR_WINDOW_LENGTH: win_len_in   = csr_pwdata[WIN_W-1:0];
            CSR_OUTPUT_SCALE:  scale_in     = csr_pwdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RST;
         win_len_ff   <= WIN_LEN_RST;
         scale_ff     <= SCALE_RST;
      end else begin
         tap_count_ff <= tap_count_in;
         win_len_ff   <= win_len_in;
         scale_ff     <= scale_in;
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_TAP_COUNT:     csr_prdata = CSR_DATA_W'(tap_count_ff);
         CSR_WINDOW_LENGTH: csr_prdata = CSR_DATA_W'(win_len_ff);
         CSR_OUTPUT_SCALE:  csr_prdata = CSR_DATA_W'(scale_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer ----------------
   assign accept  = req_valid && req_ready;
   assign smp_acc = accept && (req_func == FUNC_SAMPLE);
   assign tap_acc = accept && (req_func == FUNC_TAP);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_func == FUNC_SAMPLE)) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + TAP_IDX_W'(1);
            if (cnt_ff == TAP_IDX_W'(TAP_DEPTH - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC:   state_in = ST_SQR;
         ST_SQR:   state_in = ST_CMP;
         ST_CMP:   state_in = win_end ? ST_SCALE : ST_IDLE;
         ST_SCALE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // per-unit controls
   always_comb begin
      cell_ctrl.shift  = smp_acc;
      cell_ctrl.rotate = (state_ff == ST_RUN);
      mac_ctrl.clear   = smp_acc;
      mac_ctrl.take    = (state_ff == ST_RUN) && (TAP_CNT_W'(cnt_ff) < tap_count_ff);
      peak_ctrl.sqr    = (state_ff == ST_SQR);
      peak_ctrl.cmp    = (state_ff == ST_CMP);
      peak_ctrl.scale  = (state_ff == ST_SCALE);
   end

   // ---------------- cell row ----------------
   assign req_value.re = req_value_re;
   assign req_value.im = req_value_im;

   for (genvar k = 0; k < TAP_DEPTH; k++) begin : g_row
      cplx_type left_smp;
      if (k == 0) begin : g_head
         assign left_smp = req_value;
      end else begin : g_body
         assign left_smp = smp_chain[k-1];
      end
      assign tap_we[k] = tap_acc && (req_tap_index == TAP_IDX_W'(k));

      dsssmf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .tap_we    (tap_we[k]),
         .tap_load  (req_value),
         .left_smp  (left_smp),
         .right_smp (smp_chain[(k + 1) % TAP_DEPTH]),
         .right_tap (tap_chain[(k + 1) % TAP_DEPTH]),
         .smp       (smp_chain[k]),
         .tap       (tap_chain[k])
      );
   end

   // ---------------- MAC and peak ----------------
   dsssmf_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .tap    (tap_chain[0]),
      .smp    (smp_chain[0]),
      .acc_re (acc_re),
      .acc_im (acc_im)
   );

   dsssmf_peak u_peak (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (peak_ctrl),
      .acc_re        (acc_re),
      .acc_im        (acc_im),
      .window_length (win_len_ff),
      .output_scale  (scale_ff),
      .win_end       (win_end),
      .peak_re       (peak_re),
      .peak_im       (peak_im)
   );

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_peak_re_in = rsp_peak_re_ff;
      rsp_peak_im_in = rsp_peak_im_ff;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_peak_re_in = peak_re;
         rsp_peak_im_in = peak_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_peak_re_ff <= rsp_peak_re_in;
      rsp_peak_im_ff <= rsp_peak_im_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_peak_re = rsp_peak_re_ff;
   assign rsp_peak_im = rsp_peak_im_ff;

   // ---------------- assertions ----------------
   `DMF_ASSERT(a_run_start, clock, reset, (smp_acc |=> (state_ff == ST_RUN && cnt_ff == '0)), "rotation did not start at step zero")
   `DMF_ASSERT(a_run_len, clock, reset, ((state_ff == ST_RUN && cnt_ff == TAP_IDX_W'(TAP_DEPTH - 1)) |=> (state_ff == ST_ACC)), "rotation length wrong")
   `DMF_NEVER(a_win_end_cmp, clock, reset, (win_end && state_ff != ST_CMP), "window end outside compare step")
   `DMF_ASSERT(a_emit_load, clock, reset, ((state_ff == ST_EMIT && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff), "window result not presented")

endmodule

/* rtl/dsssmf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsssmf_cell
// One filter position: holds a delay line sample and a tap. Samples shift
// toward older positions on a new request; both rotate toward the head
// during the multiply-accumulate pass.
// ----------------------------------------------------------------------------
module dsssmf_cell
   import dsssmf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          tap_we,
   input  cplx_type      tap_load,
   input  cplx_type      left_smp,
   input  cplx_type      right_smp,
   input  cplx_type      right_tap,
   output cplx_type      smp,
   output cplx_type      tap
);

   cplx_type smp_ff, smp_in;
   cplx_type tap_ff, tap_in;

   // sample: shift in from the newer side, or rotate in from the older side
   always_comb begin
      smp_in = smp_ff;
      if (ctrl.shift) begin
         smp_in = left_smp;
      end else if (ctrl.rotate) begin
         smp_in = right_smp;
      end
   end

   // tap: direct load, or rotate with the samples
   always_comb begin
      tap_in = tap_ff;
      if (tap_we) begin
         tap_in = tap_load;
      end else if (ctrl.rotate) begin
         tap_in = right_tap;
      end
   end

   // delay line starts cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         smp_ff <= '0;
      end else begin
         smp_ff <= smp_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff <= tap_in;
   end

   assign smp = smp_ff;
   assign tap = tap_ff;

endmodule

/* rtl/dsssmf_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsssmf_mac
// Complex multiply-accumulate at the head of the cell row. Four products are
// registered, then folded into the exact real and imaginary sums.
// ----------------------------------------------------------------------------
module dsssmf_mac
   import dsssmf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mac_ctrl_type            ctrl,
   input  cplx_type                tap,
   input  cplx_type                smp,
   output logic signed [ACC_W-1:0] acc_re,
   output logic signed [ACC_W-1:0] acc_im
);

   logic signed [MUL_W-1:0] rr_ff, rr_in, ii_ff, ii_in;
   logic signed [MUL_W-1:0] ri_ff, ri_in, ir_ff, ir_in;
   logic                    take_ff, take_in;
   logic signed [ACC_W-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;

   // product stage, no conjugation
   always_comb begin
      rr_in   = MUL_W'(tap.re) * MUL_W'(smp.re);
      ii_in   = MUL_W'(tap.im) * MUL_W'(smp.im);
      ri_in   = MUL_W'(tap.re) * MUL_W'(smp.im);
      ir_in   = MUL_W'(tap.im) * MUL_W'(smp.re);
      take_in = ctrl.take;
   end

   always_ff @(posedge clock) begin
      rr_ff <= rr_in;
      ii_ff <= ii_in;
      ri_ff <= ri_in;
      ir_ff <= ir_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         take_ff <= 1'b0;
      end else begin
         take_ff <= take_in;
      end
   end

   // accumulate stage, cleared when a new sample arrives
   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (ctrl.clear) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (take_ff) begin
         acc_re_in = acc_re_ff + ACC_W'(rr_ff) - ACC_W'(ii_ff);
         acc_im_in = acc_im_ff + ACC_W'(ri_ff) + ACC_W'(ir_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
   end

   assign acc_re = acc_re_ff;
   assign acc_im = acc_im_ff;

endmodule

/* rtl/dsssmf_peak.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsssmf_peak
// Rescales the filter sum, tracks the largest squared magnitude over the
// window and produces the scaled, saturated peak at the window end.
// ----------------------------------------------------------------------------
module dsssmf_peak
   import dsssmf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  peak_ctrl_type           ctrl,
   input  logic signed [ACC_W-1:0] acc_re,
   input  logic signed [ACC_W-1:0] acc_im,
   input  logic [WIN_W-1:0]        window_length,
   input  logic [SCALE_W-1:0]      output_scale,
   output logic                    win_end,
   output logic signed [OUT_W-1:0] peak_re,
   output logic signed [OUT_W-1:0] peak_im
);

   logic signed [Y_W-1:0]   y_re, y_im;
   logic signed [MAG_W-1:0] sq_re_s, sq_im_s;
   logic signed [Y_W-1:0]   y_re_ff, y_re_in, y_im_ff, y_im_in;
   logic [MAG_W-1:0]        sq_re_ff, sq_re_in, sq_im_ff, sq_im_in;
   logic [MAG_W-1:0]        mag;
   logic [MAG_W-1:0]        best_mag_ff, best_mag_in;
   logic signed [Y_W-1:0]   best_re_ff, best_re_in, best_im_ff, best_im_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [WIN_W-1:0]        wlen, pos_next;
   logic signed [SCL_W-1:0] scale_s;
   logic signed [SCL_W-1:0] sp_re_ff, sp_re_in, sp_im_ff, sp_im_in;

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SH_W-1:0] v);
      logic all_one, all_zero;
      all_one  = &v[SH_W-1:OUT_W-1];
      all_zero = ~|v[SH_W-1:OUT_W-1];
      if (all_one || all_zero) begin
         sat_out = v[OUT_W-1:0];
      end else if (v[SH_W-1]) begin
         sat_out = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         sat_out = {1'b0, {(OUT_W-1){1'b1}}};
      end
   endfunction

   // floor shift by dropping fraction bits, then square
   always_comb begin
      y_re     = $signed(acc_re[ACC_W-1:FRAC_SHIFT]);
      y_im     = $signed(acc_im[ACC_W-1:FRAC_SHIFT]);
      sq_re_s  = MAG_W'(y_re) * MAG_W'(y_re);
      sq_im_s  = MAG_W'(y_im) * MAG_W'(y_im);
      y_re_in  = ctrl.sqr ? y_re : y_re_ff;
      y_im_in  = ctrl.sqr ? y_im : y_im_ff;
      sq_re_in = ctrl.sqr ? $unsigned(sq_re_s) : sq_re_ff;
      sq_im_in = ctrl.sqr ? $unsigned(sq_im_s) : sq_im_ff;
   end

   always_ff @(posedge clock) begin
      y_re_ff  <= y_re_in;
      y_im_ff  <= y_im_in;
      sq_re_ff <= sq_re_in;
      sq_im_ff <= sq_im_in;
   end

   // effective window length: zero acts as one, capped at the maximum
   always_comb begin
      if (window_length == '0) begin
         wlen = WIN_W'(1);
      end else if (window_length > WIN_W'(WIN_MAX)) begin
         wlen = WIN_W'(WIN_MAX);
      end else begin
         wlen = window_length;
      end
      pos_next = WIN_W'(pos_ff) + WIN_W'(1);
      win_end  = ctrl.cmp && (pos_next >= wlen);
   end

   // peak tracking: strictly greater replaces, cleared after the window end
   always_comb begin
      mag         = sq_re_ff + sq_im_ff;
      best_mag_in = best_mag_ff;
      best_re_in  = best_re_ff;
      best_im_in  = best_im_ff;
      pos_in      = pos_ff;
      if (ctrl.scale) begin
         best_mag_in = '0;
         best_re_in  = '0;
         best_im_in  = '0;
      end else if (ctrl.cmp) begin
         if (mag > best_mag_ff) begin
            best_mag_in = mag;
            best_re_in  = y_re_ff;
            best_im_in  = y_im_ff;
         end
         pos_in = win_end ? '0 : pos_next[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_mag_ff <= '0;
         best_re_ff  <= '0;
         best_im_ff  <= '0;
         pos_ff      <= '0;
      end else begin
         best_mag_ff <= best_mag_in;
         best_re_ff  <= best_re_in;
         best_im_ff  <= best_im_in;
         pos_ff      <= pos_in;
      end
   end

   // Q16 gain on the held peak
   always_comb begin
      scale_s  = SCL_W'($signed({1'b0, output_scale}));
      sp_re_in = ctrl.scale ? SCL_W'(best_re_ff) * scale_s : sp_re_ff;
      sp_im_in = ctrl.scale ? SCL_W'(best_im_ff) * scale_s : sp_im_ff;
   end

   always_ff @(posedge clock) begin
      sp_re_ff <= sp_re_in;
      sp_im_ff <= sp_im_in;
   end

   // floor shift by 16 and saturate
   assign peak_re = sat_out($signed(sp_re_ff[SCL_W-1:SCL_SHIFT]));
   assign peak_im = sat_out($signed(sp_im_ff[SCL_W-1:SCL_SHIFT]));

endmodule
